/* sv/roman_numeral_encoder_top_defines.svh */
// Assertion macros shared by the Roman numeral encoder RTL.
`ifndef ROMAN_NUMERAL_ENCODER_TOP_DEFINES_SVH
`define ROMAN_NUMERAL_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RNE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rne: implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RNE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rne: next-cycle check failed");

`endif

/* sv/rne_pkg.sv */
// Shared types, constants and decode functions for the Roman numeral encoder.
package rne_pkg;

    localparam int unsigned VALUE_W  = 13;
    localparam int unsigned SYMBOL_W = 7;
    localparam int unsigned PLACE_W  = 10;

    localparam logic [VALUE_W-1:0] LIMIT_VALUE = 13'd5000;
    localparam int unsigned        MAX_RUN     = 16;

    localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

    // decimal positions, thousands down to units
    localparam logic [1:0] POS_THOUSANDS = 2'd3;
    localparam logic [1:0] POS_HUNDREDS  = 2'd2;
    localparam logic [1:0] POS_TENS      = 2'd1;
    localparam logic [1:0] POS_UNITS     = 2'd0;

    typedef logic [3:0] digit_t;
    typedef logic [1:0] pos_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_EMIT,
        ST_ERROR
    } state_t;

    // result of the shared compare/subtract unit
    typedef struct packed {
        logic [VALUE_W-1:0] diff;
        logic               ge;
    } sub_res_t;

    // one character of the current digit's pattern
    typedef struct packed {
        logic [SYMBOL_W-1:0] sym;
        logic [2:0]          dlen;
    } emit_info_t;

    function automatic logic [PLACE_W-1:0] place_of(input pos_t pos);
        logic [PLACE_W-1:0] p;
        unique case (pos)
            POS_THOUSANDS: p = 10'd1000;
            POS_HUNDREDS:  p = 10'd100;
            POS_TENS:      p = 10'd10;
            default:       p = 10'd1;
        endcase
        return p;
    endfunction

    function automatic logic [SYMBOL_W-1:0] letter_of(input logic [2:0] idx);
        logic [SYMBOL_W-1:0] s;
        unique case (idx)
            3'd0:    s = SYM_I;
            3'd1:    s = SYM_V;
            3'd2:    s = SYM_X;
            3'd3:    s = SYM_L;
            3'd4:    s = SYM_C;
            3'd5:    s = SYM_D;
            3'd6:    s = SYM_M;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage

/* sv/roman_numeral_encoder_top.sv */
// Top level of the Roman numeral encoder: sequencer, digit store, output register.
// Usage:
//   Input channel (in_valid/in_ready, value) takes one 13-bit number per
//   transfer. The result channel (out_valid/out_ready, symbol, last,
//   out_of_range) returns the numeral one ASCII letter per transfer;
//   last marks the final letter. Runs longer than 16 letters are cut
//   after the 16th, which carries last.
//   A value of 0 or 5000 and up gives a single transfer with symbol 0,
//   last and out_of_range set.
// Timing:
//   Digits are found by repeated subtraction of 1000, 100 and 10 in one
//   shared compare/subtract unit. Letters then leave at one per cycle while
//   out_ready stays high; each zero digit above the last letter is passed
//   over without a letter. in_ready is high only between items.
// Stalls and reset:
//   A single output register holds the current letter; while a letter is
//   held and out_ready is low, the next letter waits. The next input can be taken
//   while the final letter still sits in the output register. rst_n returns to idle.
`include "roman_numeral_encoder_top_defines.svh"

module roman_numeral_encoder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rne_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rne_pkg::SYMBOL_W-1:0] symbol,
    output logic                         last,
    output logic                         out_of_range
);
    import rne_pkg::*;

    state_t              state_reg, state_next;
    logic [VALUE_W-1:0]  rem_reg, rem_next;
    pos_t                pos_reg, pos_next;
    digit_t              dcnt_reg, dcnt_next;
    digit_t              digit_reg [0:3];
    digit_t              digit_next [0:3];
    logic [2:0]          k_reg, k_next;
    logic [3:0]          run_reg, run_next;

    logic                out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0] symbol_reg, symbol_next;
    logic                last_reg, last_next;
    logic                oor_reg, oor_next;

    logic                in_xfer;
    logic                out_free;
    logic                load;
    logic                lower_zero;
    logic                digit_end;
    logic                run_full;
    sub_res_t            sub_res;
    emit_info_t          info;

    // shared unit: remainder against current place value
    rne_sub_unit u_sub (
        .rem   (rem_reg),
        .place (place_of(pos_reg)),
        .res   (sub_res)
    );

    // pattern decode of the digit at the current position
    rne_emit u_emit (
        .digit (digit_reg[pos_reg]),
        .pos   (pos_reg),
        .k     (k_reg),
        .info  (info)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // no letters left below the current position
    always_comb
    begin
        lower_zero = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (2'(i) < pos_reg && digit_reg[i] != 4'd0) begin
                lower_zero = 1'b0;
            end
        end
    end

    assign digit_end = (k_reg + 3'd1 == info.dlen);
    assign run_full  = (run_reg == 4'(MAX_RUN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and payload registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        dcnt_reg   <= dcnt_next;
        k_reg      <= k_next;
        run_reg    <= run_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        oor_reg    <= oor_next;
        for (int i = 0; i < 4; i++) begin
            digit_reg[i] <= digit_next[i];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        dcnt_next   = dcnt_reg;
        k_next      = k_reg;
        run_next    = run_reg;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        oor_next    = oor_reg;
        load        = 1'b0;
        for (int i = 0; i < 4; i++) begin
            digit_next[i] = digit_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    rem_next  = value;
                    pos_next  = POS_THOUSANDS;
                    dcnt_next = 4'd0;
                    k_next    = 3'd0;
                    run_next  = 4'd0;
                    if (value == '0 || value >= LIMIT_VALUE) begin
                        state_next = ST_ERROR;
                    end else begin
                        state_next = ST_EXTRACT;
                    end
                end
            end
            ST_EXTRACT:
            begin
                if (sub_res.ge) begin
                    rem_next  = sub_res.diff;
                    dcnt_next = dcnt_reg + 4'd1;
                end else begin
                    digit_next[pos_reg] = dcnt_reg;
                    dcnt_next           = 4'd0;
                    if (pos_reg == POS_TENS) begin
                        // remainder below ten is the units digit
                        digit_next[POS_UNITS] = rem_reg[3:0];
                        pos_next              = POS_THOUSANDS;
                        state_next            = ST_EMIT;
                    end else begin
                        pos_next = pos_reg - 2'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (digit_reg[pos_reg] == 4'd0) begin
                    // zero digit: nothing to send
                    pos_next = pos_reg - 2'd1;
                    k_next   = 3'd0;
                end else if (out_free) begin
                    load        = 1'b1;
                    symbol_next = info.sym;
                    last_next   = (digit_end && lower_zero) || run_full;
                    oor_next    = 1'b0;
                    run_next    = run_reg + 4'd1;
                    if ((digit_end && lower_zero) || run_full) begin
                        state_next = ST_IDLE;
                    end else if (digit_end) begin
                        pos_next = pos_reg - 2'd1;
                        k_next   = 3'd0;
                    end else begin
                        k_next = k_reg + 3'd1;
                    end
                end
            end
            ST_ERROR:
            begin
                if (out_free) begin
                    load        = 1'b1;
                    symbol_next = SYM_NONE;
                    last_next   = 1'b1;
                    oor_next    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol       = symbol_reg;
    assign last         = last_reg;
    assign out_of_range = oor_reg;

    `RNE_ASSERT_IMP(a_err_is_last, out_valid && out_of_range, last && symbol == SYM_NONE)
    `RNE_ASSERT_IMP(a_letter_legal, out_valid && !out_of_range,
        symbol == SYM_I || symbol == SYM_V || symbol == SYM_X || symbol == SYM_L ||
        symbol == SYM_C || symbol == SYM_D || symbol == SYM_M)
    `RNE_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
    `RNE_ASSERT_IMP(a_rem_in_range, state_reg == ST_EXTRACT, rem_reg < LIMIT_VALUE)

endmodule

/* sv/rne_sub_unit.sv */
// Shared compare-and-subtract unit used to peel off decimal digits.
module rne_sub_unit (
    input  logic [rne_pkg::VALUE_W-1:0] rem,
    input  logic [rne_pkg::PLACE_W-1:0] place,
    output rne_pkg::sub_res_t           res
);
    import rne_pkg::*;

    logic [VALUE_W:0] wide_diff;

    assign wide_diff = {1'b0, rem} - {{(VALUE_W + 1 - PLACE_W){1'b0}}, place};
    assign res.ge    = ~wide_diff[VALUE_W];
    assign res.diff  = wide_diff[VALUE_W-1:0];

endmodule

/* sv/rne_emit.sv */
// Letter pattern decoder: k-th character and length of one digit's numeral.
module rne_emit (
    input  rne_pkg::digit_t     digit,
    input  rne_pkg::pos_t       pos,
    input  logic [2:0]          k,
    output rne_pkg::emit_info_t info
);
    import rne_pkg::*;

    logic [2:0] unit_idx;
    logic [2:0] five_idx;
    logic [2:0] ten_idx;
    logic [2:0] idx;

    assign unit_idx = {pos, 1'b0};
    assign five_idx = unit_idx + 3'd1;
    assign ten_idx  = unit_idx + 3'd2;

    always_comb
    begin
        idx       = unit_idx;
        info.dlen = 3'd0;
        if (pos == POS_THOUSANDS) begin
            // no five letter: plain run of M, MMMM for four
            info.dlen = digit[2:0];
            idx       = unit_idx;
        end else if (digit == 4'd4) begin
            info.dlen = 3'd2;
            idx       = (k == 3'd0) ? unit_idx : five_idx;
        end else if (digit == 4'd9 && pos == POS_UNITS) begin
            info.dlen = 3'd2;
            idx       = (k == 3'd0) ? unit_idx : ten_idx;
        end else if (digit == 4'd9) begin
            // LXXXX / DCCCC
            info.dlen = 3'd5;
            idx       = (k == 3'd0) ? five_idx : unit_idx;
        end else if (digit >= 4'd5) begin
            info.dlen = 3'(digit - 4'd4);
            idx       = (k == 3'd0) ? five_idx : unit_idx;
        end else begin
            info.dlen = digit[2:0];
            idx       = unit_idx;
        end
        info.sym = letter_of(idx);
    end

endmodule
